// File: rtl/bffa_pkg.sv
package bffa_pkg;

	localparam int SEGMENTS_DEF      = 256;
	localparam int SEGMENT_BYTES_DEF = 16;

	// map word geometry
	localparam int WORD_BITS = 16;
	localparam int BIT_W     = 4;

	localparam int SIZE_W = 16;
	localparam int ADDR_W = 12;
	localparam int SB_W   = 9;

	// reciprocal used to divide the byte size by the segment size
	localparam int RCP_SHIFT = 24;
	localparam int RCP_W     = 25;
	localparam int NEED_W    = 17;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QMUL,
		ST_NEED,
		ST_SCAN,
		ST_MARK
	} state_t;

	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} map_ctl_t;

endpackage

// File: rtl/bffa_map.sv
module bffa_map #(
	parameter int WORDS = (bffa_pkg::SEGMENTS_DEF + bffa_pkg::WORD_BITS - 1) / bffa_pkg::WORD_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bffa_pkg::map_ctl_t                 ctl,
	input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] rd_addr,
	input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] wr_addr,
	input  logic [bffa_pkg::WORD_BITS-1:0]     wr_data,
	output logic [bffa_pkg::WORD_BITS-1:0]     rd_data
);

	logic [bffa_pkg::WORD_BITS-1:0] mem [WORDS];
	logic [WORDS-1:0]               vld_q;
	logic [bffa_pkg::WORD_BITS-1:0] data_s1;
	logic                           vld_s1;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd) begin
			data_s1 <= mem[rd_addr];
		end
	end

	// a word never written since reset or clear reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.wr) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd) begin
				vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = vld_s1 ? data_s1 : '0;

endmodule

// File: rtl/bitmap_first_fit_allocator_unit.sv
// channel   handshake                  payload
// request   start high, busy low       func, size_bytes
// result    done strobe, one cycle     ok, base_address
//
// clear: done shows in the cycle after the request is accepted.
// allocate: the size becomes a segment count, map words are scanned up to the hit, then
// the words the run covers are read back and marked; one map word is read per cycle. a
// scan that finds no run, or a request larger than the heap, ends with ok low.
// reset and clear empty the map at once through per-word valid bits, no sweep.
// done cannot be held off; a new request may start in the cycle done shows.
module bitmap_first_fit_allocator_unit #(
	parameter int SEGMENTS      = bffa_pkg::SEGMENTS_DEF,
	parameter int SEGMENT_BYTES = bffa_pkg::SEGMENT_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          func,
	input  logic [bffa_pkg::SIZE_W-1:0]   size_bytes,
	output logic                          done,
	output logic                          ok,
	output logic [bffa_pkg::ADDR_W-1:0]   base_address
);

	localparam int WB        = bffa_pkg::WORD_BITS;
	localparam int BW        = bffa_pkg::BIT_W;
	localparam int WORDS     = (SEGMENTS + WB - 1) / WB;
	localparam int WA_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int GI_W      = WA_W + BW;
	localparam int SW        = GI_W + 1;
	localparam int NW        = $clog2(SEGMENTS + 1);
	localparam int LAST_BITS = SEGMENTS - (WORDS - 1) * WB;
	localparam int PROD_W    = bffa_pkg::SIZE_W + bffa_pkg::RCP_W;
	localparam int QSB_W     = bffa_pkg::SIZE_W + bffa_pkg::SB_W;
	localparam int MUL_W     = GI_W + bffa_pkg::SB_W;
	localparam logic [bffa_pkg::RCP_W-1:0] RECIP =
		bffa_pkg::RCP_W'((1 << bffa_pkg::RCP_SHIFT) / SEGMENT_BYTES);

	bffa_pkg::state_t state_q, state_d;

	logic [bffa_pkg::SIZE_W-1:0] size_q;
	logic [PROD_W-1:0]           prod_q;
	logic [bffa_pkg::SIZE_W-1:0] qe_q;
	logic [bffa_pkg::SIZE_W-1:0] qsb_q;
	logic [NW-1:0]               need_q;
	logic [NW-1:0]               run_q;
	logic [WA_W-1:0]             rd_q;
	logic                        iss_q;
	logic [WA_W-1:0]             addr_s1;
	logic                        rd_vld_s1;
	logic [GI_W-1:0]             start_q;
	logic [GI_W-1:0]             end_q;
	logic [bffa_pkg::ADDR_W-1:0] base_mul_q;
	logic                        done_q;
	logic                        ok_q;
	logic [bffa_pkg::ADDR_W-1:0] base_q;

	bffa_pkg::map_ctl_t ctl;
	logic [WB-1:0]      rd_data;
	logic [WB-1:0]      wr_data;

	// need computation
	logic [bffa_pkg::SIZE_W-1:0] rem;
	logic [bffa_pkg::NEED_W-1:0] need_full;
	logic                        too_big;

	// word scan
	logic [WB-1:0]   used;
	logic            lu_has [WB];
	logic [BW-1:0]   lu_pos [WB];
	logic [SW-1:0]   run_v;
	logic [WB-1:0]   hit_vec;
	logic            hit;
	logic [BW-1:0]   hit_pos;
	logic [NW-1:0]   run_next;
	logic [GI_W-1:0] end_idx;
	logic [GI_W-1:0] start_idx;
	logic            last_s1;

	// marking
	logic [BW-1:0]   lo;
	logic [BW-1:0]   hi;
	logic [WB-1:0]   mask;
	logic [WA_W-1:0] ew;

	logic res_fire;
	logic res_ok;
	logic iss_last;

	bffa_map #(
		.WORDS (WORDS)
	) u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.rd_addr (rd_q),
		.wr_addr (addr_s1),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	// quotient estimate is low by at most one, fixed with one compare
	always_comb begin
		rem       = size_q - qsb_q;
		need_full = {1'b0, qe_q}
			+ bffa_pkg::NEED_W'(rem >= bffa_pkg::SIZE_W'(SEGMENT_BYTES))
			+ bffa_pkg::NEED_W'(1);
		too_big   = need_full > bffa_pkg::NEED_W'(SEGMENTS);
	end

	// free run ending at each bit of the word just read
	always_comb begin
		last_s1 = addr_s1 == WA_W'(WORDS - 1);
		used    = rd_data;
		for (int j = 0; j < WB; j++) begin
			if (last_s1 && j >= LAST_BITS) begin
				used[j] = 1'b1;
			end
		end
		run_v = '0;
		for (int j = 0; j < WB; j++) begin
			lu_has[j] = 1'b0;
			lu_pos[j] = '0;
			for (int k = 0; k <= j; k++) begin
				if (used[k]) begin
					lu_has[j] = 1'b1;
					lu_pos[j] = BW'(k);
				end
			end
			run_v = lu_has[j] ? SW'(j) - SW'(lu_pos[j])
				: SW'(run_q) + SW'(j + 1);
			hit_vec[j] = run_v >= SW'(need_q);
		end
		hit     = 1'b0;
		hit_pos = '0;
		for (int j = WB - 1; j >= 0; j--) begin
			if (hit_vec[j]) begin
				hit     = 1'b1;
				hit_pos = BW'(j);
			end
		end
		run_next  = lu_has[WB-1] ? NW'(SW'(WB - 1) - SW'(lu_pos[WB-1]))
			: NW'(SW'(run_q) + SW'(WB));
		end_idx   = {addr_s1, hit_pos};
		start_idx = GI_W'(SW'(end_idx) + SW'(1) - SW'(need_q));
	end

	// bits of the run inside the word being written back
	always_comb begin
		ew = end_q[GI_W-1:BW];
		lo = (addr_s1 == start_q[GI_W-1:BW]) ? start_q[BW-1:0] : '0;
		hi = (addr_s1 == ew) ? end_q[BW-1:0] : '1;
		for (int j = 0; j < WB; j++) begin
			mask[j] = (BW'(j) >= lo) && (BW'(j) <= hi);
		end
		wr_data = rd_data | mask;
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		res_fire = 1'b0;
		res_ok   = 1'b0;
		iss_last = 1'b0;
		case (state_q)
			bffa_pkg::ST_IDLE: begin
				if (start) begin
					if (func == bffa_pkg::FUNC_CLEAR) begin
						ctl.clr  = 1'b1;
						res_fire = 1'b1;
						res_ok   = 1'b1;
					end else begin
						state_d = bffa_pkg::ST_QMUL;
					end
				end
			end
			bffa_pkg::ST_QMUL: begin
				state_d = bffa_pkg::ST_NEED;
			end
			bffa_pkg::ST_NEED: begin
				if (too_big) begin
					state_d  = bffa_pkg::ST_IDLE;
					res_fire = 1'b1;
				end else begin
					state_d = bffa_pkg::ST_SCAN;
				end
			end
			bffa_pkg::ST_SCAN: begin
				ctl.rd   = iss_q && !(rd_vld_s1 && (hit || last_s1));
				iss_last = rd_q == WA_W'(WORDS - 1);
				if (rd_vld_s1) begin
					if (hit) begin
						state_d = bffa_pkg::ST_MARK;
					end else if (last_s1) begin
						state_d  = bffa_pkg::ST_IDLE;
						res_fire = 1'b1;
					end
				end
			end
			bffa_pkg::ST_MARK: begin
				ctl.rd   = iss_q;
				iss_last = rd_q == ew;
				ctl.wr   = rd_vld_s1;
				if (rd_vld_s1 && addr_s1 == ew) begin
					state_d  = bffa_pkg::ST_IDLE;
					res_fire = 1'b1;
					res_ok   = 1'b1;
				end
			end
			default: begin
				state_d = bffa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bffa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q     <= 1'b0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= ctl.rd;
			done_q    <= res_fire;
			if (state_q == bffa_pkg::ST_NEED && !too_big) begin
				iss_q <= 1'b1;
			end else if (state_q == bffa_pkg::ST_SCAN && rd_vld_s1 && hit) begin
				iss_q <= 1'b1;
			end else if (ctl.rd && iss_last) begin
				iss_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			addr_s1 <= rd_q;
		end
		case (state_q)
			bffa_pkg::ST_IDLE: begin
				size_q <= size_bytes;
				prod_q <= PROD_W'(size_bytes) * PROD_W'(RECIP);
			end
			bffa_pkg::ST_QMUL: begin
				qe_q  <= prod_q[bffa_pkg::RCP_SHIFT +: bffa_pkg::SIZE_W];
				qsb_q <= bffa_pkg::SIZE_W'(
					QSB_W'(prod_q[bffa_pkg::RCP_SHIFT +: bffa_pkg::SIZE_W])
					* QSB_W'(SEGMENT_BYTES));
			end
			bffa_pkg::ST_NEED: begin
				need_q <= NW'(need_full);
				run_q  <= '0;
				rd_q   <= '0;
			end
			bffa_pkg::ST_SCAN: begin
				if (rd_vld_s1 && hit) begin
					start_q <= start_idx;
					end_q   <= end_idx;
					rd_q    <= start_idx[GI_W-1:BW];
				end else begin
					if (rd_vld_s1) begin
						run_q <= run_next;
					end
					if (ctl.rd && !iss_last) begin
						rd_q <= rd_q + WA_W'(1);
					end
				end
			end
			bffa_pkg::ST_MARK: begin
				base_mul_q <= bffa_pkg::ADDR_W'(MUL_W'(start_q) * MUL_W'(SEGMENT_BYTES));
				if (ctl.rd && !iss_last) begin
					rd_q <= rd_q + WA_W'(1);
				end
			end
			default: begin
			end
		endcase
		if (res_fire) begin
			ok_q   <= res_ok;
			base_q <= (res_ok && state_q == bffa_pkg::ST_MARK) ? base_mul_q : '0;
		end
	end

	assign busy         = state_q != bffa_pkg::ST_IDLE;
	assign done         = done_q;
	assign ok           = ok_q;
	assign base_address = base_q;

endmodule
